// ===== hw/rtl/dq_pkg.sv =====
// shared types and constants of the double-ended queue
`default_nettype none

package dq_pkg;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [2:0] KIND_POP_BACK   = 3'd2;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
	localparam logic [2:0] KIND_PEEK_BACK  = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] push_value;
	} deq_req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [4:0]         count;
		logic               is_empty;
		logic [1:0]         status;
	} deq_rsp_t;

	// per-cell move: take from the left, take from the right, or load
	typedef struct packed {
		logic shr;
		logic shl;
		logic ld;
	} cell_ctl_t;

	// per-chain command
	typedef struct packed {
		logic             shr;
		logic             shl;
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
	} chain_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_cell.sv =====
// one storage cell of a shifting chain
`default_nettype none

module dq_cell (
	input  wire logic               clk,
	input  wire dq_pkg::cell_ctl_t  ctl,
	input  wire logic signed [31:0] from_left,
	input  wire logic signed [31:0] from_right,
	input  wire logic signed [31:0] load_value,
	output logic signed [31:0]      q
);
	import dq_pkg::*;

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.ld) begin
			data_q <= load_value;
		end else if (ctl.shr) begin
			data_q <= from_left;
		end else if (ctl.shl) begin
			data_q <= from_right;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dq_chain.sv =====
// row of cells holding the queue in order from one end
`default_nettype none

module dq_chain (
	input  wire logic               clk,
	input  wire dq_pkg::chain_ctl_t ctl,
	input  wire logic signed [31:0] push_value,
	output logic signed [31:0]      head
);
	import dq_pkg::*;

	logic signed [31:0] data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t          cctl;
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		// cell 0 takes the pushed value on a shift in, the last cell holds on a shift out
		if (i == 0) begin : g_first
			assign left_d = push_value;
		end else begin : g_mid_l
			assign left_d = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = data[i];
		end else begin : g_mid_r
			assign right_d = data[i+1];
		end

		assign cctl.shr = ctl.shr;
		assign cctl.shl = ctl.shl;
		assign cctl.ld  = ctl.wr && (ctl.wr_idx == IDX_W'(i));

		dq_cell u_cell (
			.clk        (clk),
			.ctl        (cctl),
			.from_left  (left_d),
			.from_right (right_d),
			.load_value (push_value),
			.q          (data[i])
		);
	end

	assign head = data[0];

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// top level of the bounded double-ended queue
//
//   channel | dir | handshake                 | payload
//   req     | in  | req_valid / req_stall     | deq_req_t (kind, push_value)
//   rsp     | out | rsp_valid / rsp_stall     | deq_rsp_t (read_value, count, is_empty, status)
//
// one transaction per cycle while req_stall is low: every request finishes in the cycle it is taken,
// each chain moves by at most one cell per request
// the response is registered and appears in the cycle after the accepted request
// req_stall rises only while a response is held by rsp_stall
// reset clears the count and the response valid; cell contents are not reset
`default_nettype none

module double_ended_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire dq_pkg::deq_req_t req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output dq_pkg::deq_rsp_t      rsp
);
	import dq_pkg::*;

	// two chains hold the same entries: one ordered from the front, one from the back,
	// so both ends are always at cell 0 and no cell is read at a computed address
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic               rsp_valid_q;
	deq_rsp_t           rsp_q;
	deq_rsp_t           rsp_d;
	chain_ctl_t         front_ctl;
	chain_ctl_t         back_ctl;
	logic signed [31:0] front_head;
	logic signed [31:0] back_head;
	logic               accept;
	logic               is_full;
	logic               is_nil;
	logic [IDX_W-1:0]   tail_idx;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign is_nil    = (count_q == '0);
	// first free cell, only used when not full
	assign tail_idx  = count_q[IDX_W-1:0];

	always_comb begin
		front_ctl        = '0;
		back_ctl         = '0;
		front_ctl.wr_idx = tail_idx;
		back_ctl.wr_idx  = tail_idx;
		count_d          = count_q;
		rsp_d.read_value = '0;
		rsp_d.status     = ST_OK;

		unique case (req.kind)
			KIND_PUSH_BACK: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end else begin
					// append at the tail of the front chain, shift in at the back chain
					front_ctl.wr = accept;
					back_ctl.shr = accept;
					count_d      = count_q + CNT_W'(1);
				end
			end
			KIND_PUSH_FRONT: begin
				if (is_full) begin
					rsp_d.status = ST_FULL;
				end else begin
					front_ctl.shr = accept;
					back_ctl.wr   = accept;
					count_d       = count_q + CNT_W'(1);
				end
			end
			KIND_POP_BACK: begin
				if (is_nil) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					// the front chain just forgets its last live cell
					rsp_d.read_value = back_head;
					back_ctl.shl     = accept;
					count_d          = count_q - CNT_W'(1);
				end
			end
			KIND_POP_FRONT: begin
				if (is_nil) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.read_value = front_head;
					front_ctl.shl    = accept;
					count_d          = count_q - CNT_W'(1);
				end
			end
			KIND_PEEK_FRONT: begin
				if (is_nil) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.read_value = front_head;
				end
			end
			KIND_PEEK_BACK: begin
				if (is_nil) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					rsp_d.read_value = back_head;
				end
			end
			default: begin
				// unused kinds leave everything alone
			end
		endcase

		rsp_d.count    = 5'(count_d);
		rsp_d.is_empty = (count_d == '0);
	end

	dq_chain u_front (
		.clk        (clk),
		.ctl        (front_ctl),
		.push_value (req.push_value),
		.head       (front_head)
	);

	dq_chain u_back (
		.clk        (clk),
		.ctl        (back_ctl),
		.push_value (req.push_value),
		.head       (back_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, held while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dq_checker.sv =====
// port-level checks of the double-ended queue and their binding
`default_nettype none

module dq_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire dq_pkg::deq_rsp_t rsp
);
	import dq_pkg::*;

	// every accepted transaction shows up as a response in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request produced no response");

	// a held response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.count <= 5'(DEPTH)) && (rsp.is_empty == (rsp.count == '0)))
		else $error("count out of range or empty flag mismatch");

	a_full_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> (rsp.count == 5'(DEPTH)) && (rsp.read_value == '0))
		else $error("full error with room left");

	a_empty_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY) |-> rsp.is_empty && (rsp.read_value == '0))
		else $error("empty error on a non-empty queue");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire

// ===== sim/tb_double_ended_queue.sv =====
// testbench of the double-ended queue: directed and random requests checked against a predictor
`default_nettype none

module tb_double_ended_queue;
	import dq_pkg::*;

	// kinds that the block must ignore
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	// traffic mixes of the random part
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	localparam int unsigned ITEMS_PER_PHASE = 470;
	// the slowest case stays well under this limit
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned TAIL_CYCLES = 8;

	// deque predictor plus the queue of responses still owed by the block
	class deque_scoreboard;
		logic signed [31:0] cells [DEPTH];
		logic [IDX_W-1:0]   head;
		logic [CNT_W-1:0]   occupancy;
		deq_rsp_t           owed_rsp [$];
		int                 errors;

		function new();
			head = '0;
			occupancy = '0;
			errors = 0;
		endfunction

		// apply one accepted request to the shadow deque and queue its response
		function void note_request(deq_req_t r);
			deq_rsp_t         want;
			logic [IDX_W-1:0] back_slot;
			want = '0;
			// back entry sits at head + occupancy - 1, wrapping in the index width
			back_slot = head + occupancy[IDX_W-1:0] - 1'b1;
			case (r.kind)
			KIND_PUSH_BACK: begin
				if (occupancy == CNT_W'(DEPTH)) begin
					want.status = ST_FULL;
				end else begin
					cells[IDX_W'(head + occupancy[IDX_W-1:0])] = r.push_value;
					occupancy = occupancy + 1'b1;
				end
			end
			KIND_PUSH_FRONT: begin
				if (occupancy == CNT_W'(DEPTH)) begin
					want.status = ST_FULL;
				end else begin
					head = head - 1'b1;
					cells[head] = r.push_value;
					occupancy = occupancy + 1'b1;
				end
			end
			KIND_POP_BACK: begin
				if (occupancy == 0) begin
					want.status = ST_EMPTY;
				end else begin
					want.read_value = cells[back_slot];
					occupancy = occupancy - 1'b1;
				end
			end
			KIND_POP_FRONT: begin
				if (occupancy == 0) begin
					want.status = ST_EMPTY;
				end else begin
					want.read_value = cells[head];
					head = head + 1'b1;
					occupancy = occupancy - 1'b1;
				end
			end
			KIND_PEEK_FRONT: begin
				if (occupancy == 0) want.status = ST_EMPTY;
				else want.read_value = cells[head];
			end
			KIND_PEEK_BACK: begin
				if (occupancy == 0) want.status = ST_EMPTY;
				else want.read_value = cells[back_slot];
			end
			default: begin
				// spare kinds: no change, plain ok response
			end
			endcase
			want.count = occupancy;
			want.is_empty = (occupancy == 0);
			owed_rsp.push_back(want);
		endfunction

		// compare one accepted response with the oldest one owed
		function void check_response(deq_rsp_t got);
			deq_rsp_t want;
			if (owed_rsp.size() == 0) begin
				$error("response transaction with no request outstanding");
				errors++;
				return;
			end
			want = owed_rsp.pop_front();
			if (got.read_value !== want.read_value) begin
				$error("read_value expected %0d got %0d", want.read_value, got.read_value);
				errors++;
			end
			if (got.count !== want.count) begin
				$error("count expected %0d got %0d", want.count, got.count);
				errors++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty expected %0b got %0b", want.is_empty, got.is_empty);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0d got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	deq_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	deq_rsp_t rsp;

	// idling percentages of the current phase
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles = 0;

	deque_scoreboard sb = new();

	double_ended_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_double_ended_queue NOT OK");
			$finish;
		end
	end

	// monitor: both handshakes sampled at the edge, request noted before its response
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) sb.note_request(req);
			if (rsp_valid && !rsp_stall) sb.check_response(rsp);
		end
		// receiver back-pressure for the next cycle
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// one request transaction, with random idle cycles ahead of it
	task automatic send(logic [2:0] kind, logic signed [31:0] value);
		deq_req_t r;
		r.kind = kind;
		r.push_value = value;
		while ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		// payload stays put while stalled
		do @(posedge clk); while (req_stall);
	endtask

	// hold the sender off until every owed response has been checked
	task automatic wait_drained();
		req_valid <= 1'b0;
		// let the monitor see the last request before polling the owed queue
		@(posedge clk);
		while (sb.owed_rsp.size() != 0) @(posedge clk);
	endtask

	// mostly random words, now and then an extreme one
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 19))
		0: return 32'sh7fff_ffff;
		1: return 32'sh8000_0000;
		2: return '0;
		3: return -32'sd1;
		default: return $urandom;
		endcase
	endfunction

	// kind drawn with a bias that depends on the current traffic mix
	function automatic logic [2:0] pick_kind(int mix);
		int unsigned roll;
		int unsigned push_share;
		roll = $urandom_range(0, 99);
		push_share = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 22 : 42;
		if (roll < 3) return $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
		if (roll < 3 + push_share) return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
		if (roll < 13 + push_share) return $urandom_range(0, 1) ? KIND_PEEK_FRONT : KIND_PEEK_BACK;
		return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
	endfunction

	initial begin
		int mix;
		int mix_left;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-deque errors on every read kind, then the spare kinds
		send(KIND_POP_BACK, $urandom);
		send(KIND_POP_FRONT, $urandom);
		send(KIND_PEEK_FRONT, $urandom);
		send(KIND_PEEK_BACK, $urandom);
		send(KIND_SPARE_6, 32'sh7fff_ffff);
		send(KIND_SPARE_7, -32'sd1);
		// fill from both ends with mostly extreme values, so the head wraps below zero
		for (int i = 0; i < DEPTH; i++) begin
			send(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
			     (i % 4 == 0) ? 32'sh7fff_ffff : (i % 4 == 1) ? 32'sh8000_0000 :
			     (i % 4 == 2) ? 32'sh0 : $urandom);
		end
		// full errors at both ends, then both peeks on a full deque
		send(KIND_PUSH_BACK, $urandom);
		send(KIND_PUSH_FRONT, $urandom);
		send(KIND_PEEK_FRONT, $urandom);
		send(KIND_PEEK_BACK, $urandom);

		// random phases: no idling, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			case (phase)
			0: begin
				gap_pct = 0;
				stall_pct = 0;
			end
			1: begin
				gap_pct = 50;
				stall_pct = 0;
			end
			2: begin
				gap_pct = 0;
				stall_pct = 50;
			end
			default: begin
				gap_pct = 14;
				stall_pct = 14;
			end
			endcase
			mix_left = 0;
			mix = MIX_EVEN;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// swing between filling and draining so full and empty come up often
				if (mix_left == 0) begin
					mix = $urandom_range(MIX_FILL, MIX_EVEN);
					mix_left = $urandom_range(10, 40);
				end
				mix_left--;
				send(pick_kind(mix), pick_value());
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed_rsp.size() == 0) begin
			$display("tb_double_ended_queue OK");
		end else begin
			$display("tb_double_ended_queue NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/dq_pkg.sv
hw/rtl/dq_cell.sv
hw/rtl/dq_chain.sv
hw/rtl/double_ended_queue.sv
hw/rtl/dq_checker.sv
sim/tb_double_ended_queue.sv
